/* rtl/core/rlp_pkg.sv */
// rlp_pkg: request codes, header constants and the burst descriptor shared by
// the stream encoder modules. No dependencies.
package rlp_pkg;

    // Request codes on req_type; the fourth code is unused and dropped.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_CONT  = 2'd1;
    localparam logic [1:0] REQ_LIST  = 2'd2;

    // Header bases.
    localparam logic [7:0] STR_SHORT  = 8'h80;
    localparam logic [7:0] STR_LONG   = 8'hb7;
    localparam logic [7:0] LIST_SHORT = 8'hc0;
    localparam logic [7:0] LIST_LONG  = 8'hf7;

    // Longest length that still fits a one-byte header.
    localparam logic [31:0] SHORT_MAX = 32'd55;
    // Single nonzero bytes below this value encode as themselves.
    localparam logic [7:0] SINGLE_LIMIT = 8'h80;

    // One header byte, up to four length bytes and one payload byte.
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    // Output bytes caused by one input item.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
        logic                      err;
    } burst_t;

endpackage

/* rtl/core/rlp_stream_encoder.sv */
// rlp_stream_encoder: top level of the recursive-length-prefix stream encoder.
// Depends on rlp_pkg, rlp_front, rlp_queue and rlp_back.
//
// The encoder takes one request per cycle while in_stall is low and turns it
// into one to six output bytes: a string start gives a single-byte form or its
// header (short, or long with big-endian length bytes) and the first payload
// byte; a continuing byte passes through with out_last on the byte that
// completes the item, a list request gives only the list header, and a
// continuing byte with no item open gives one byte of zero with out_error set.
// The output side delivers one byte per cycle while out_stall is low, so the
// sustained rate is one request per cycle while each request yields a single
// byte (the payload stream); a request with more bytes holds the output for
// each. The front classifies each request in the cycle it is accepted and
// hands a descriptor of its byte burst to a QUEUE_DEPTH-entry queue; the back
// serialiser drains that queue one byte per cycle while out_stall is low,
// which sets the rate. in_stall rises only while the queue is full, so header
// bursts are absorbed while payload bytes keep flowing. Bytes cross the queue
// and then the output register. Code 3 is accepted and dropped with no output.
module rlp_stream_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] payload_len,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_error
);

    rlp_pkg::burst_t push_data;
    rlp_pkg::burst_t head;
    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;

    // Front: accept, track the open item, build the burst.
    rlp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .payload_len (payload_len),
        .data_byte   (data_byte),
        .q_full      (q_full),
        .q_push      (push),
        .q_data      (push_data)
    );

    // Decoupling queue: lets the front keep accepting while a burst drains.
    rlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (head),
        .valid   (q_valid),
        .full    (q_full)
    );

    // Back: one byte per transfer into the output register.
    rlp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_valid   (q_valid),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_error (out_error)
    );

endmodule

/* rtl/core/rlp_front.sv */
// rlp_front: accepts requests, tracks the open item and builds the burst of
// output bytes for each request. Depends on rlp_pkg.
module rlp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  logic [31:0]          payload_len,
    input  logic [7:0]           data_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output rlp_pkg::burst_t      q_data
);

    logic [31:0]                  remaining_reg;
    logic [31:0]                  remaining_next;
    logic                         accept;
    logic                         len_long;
    logic [rlp_pkg::CNT_W-1:0]    n_len;
    logic [31:0]                  aligned;
    rlp_pkg::burst_t              burst;
    logic                         emits;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign len_long = payload_len > rlp_pkg::SHORT_MAX;

    // Minimal number of big-endian length bytes.
    always_comb
    begin
        if (payload_len[31:24] != 8'h00)
            n_len = 3'd4;
        else if (payload_len[23:16] != 8'h00)
            n_len = 3'd3;
        else if (payload_len[15:8] != 8'h00)
            n_len = 3'd2;
        else
            n_len = 3'd1;
    end

    // Left-align the significant length bytes.
    always_comb
    begin
        case (n_len)
            3'd4:    aligned = payload_len;
            3'd3:    aligned = {payload_len[23:0], 8'h00};
            3'd2:    aligned = {payload_len[15:0], 16'h0000};
            default: aligned = {payload_len[7:0], 24'h000000};
        endcase
    end

    always_comb
    begin
        burst = '0;
        emits = 1'b1;
        case (req_type)
            rlp_pkg::REQ_START:
            begin
                if (payload_len == 32'd1 && data_byte < rlp_pkg::SINGLE_LIMIT)
                begin
                    // lone zero byte becomes the empty-string code
                    burst.bytes[0] = (data_byte == 8'h00) ? rlp_pkg::STR_SHORT : data_byte;
                    burst.count    = 3'd1;
                    burst.last     = 1'b1;
                end
                else if (payload_len == 32'd0)
                begin
                    burst.bytes[0] = rlp_pkg::STR_SHORT;
                    burst.count    = 3'd1;
                    burst.last     = 1'b1;
                end
                else if (!len_long)
                begin
                    burst.bytes[0] = rlp_pkg::STR_SHORT + payload_len[7:0];
                    burst.bytes[1] = data_byte;
                    burst.count    = 3'd2;
                    burst.last     = (payload_len == 32'd1);
                end
                else
                begin
                    burst.bytes[0] = rlp_pkg::STR_LONG + {5'b00000, n_len};
                    burst.bytes[1] = aligned[31:24];
                    burst.bytes[2] = aligned[23:16];
                    burst.bytes[3] = aligned[15:8];
                    burst.bytes[4] = aligned[7:0];
                    for (int j = 2; j < rlp_pkg::MAX_BYTES; j++)
                    begin
                        if (3'(j) == n_len + 3'd1)
                            burst.bytes[j] = data_byte;
                    end
                    burst.count = n_len + 3'd2;
                    burst.last  = 1'b0;
                end
            end
            rlp_pkg::REQ_CONT:
            begin
                burst.count = 3'd1;
                if (remaining_reg == 32'd0)
                begin
                    burst.err = 1'b1;
                end
                else
                begin
                    burst.bytes[0] = data_byte;
                    burst.last     = (remaining_reg == 32'd1);
                end
            end
            rlp_pkg::REQ_LIST:
            begin
                burst.last = 1'b1;
                if (!len_long)
                begin
                    burst.bytes[0] = rlp_pkg::LIST_SHORT + payload_len[7:0];
                    burst.count    = 3'd1;
                end
                else
                begin
                    burst.bytes[0] = rlp_pkg::LIST_LONG + {5'b00000, n_len};
                    burst.bytes[1] = aligned[31:24];
                    burst.bytes[2] = aligned[23:16];
                    burst.bytes[3] = aligned[15:8];
                    burst.bytes[4] = aligned[7:0];
                    burst.count    = n_len + 3'd1;
                end
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        if (accept)
        begin
            case (req_type)
                rlp_pkg::REQ_START:
                    remaining_next = (payload_len == 32'd0) ? 32'd0 : payload_len - 32'd1;
                rlp_pkg::REQ_CONT:
                    if (remaining_reg != 32'd0)
                        remaining_next = remaining_reg - 32'd1;
                rlp_pkg::REQ_LIST:
                    remaining_next = 32'd0;
                default:
                    remaining_next = remaining_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remaining_reg <= 32'd0;
        else
            remaining_reg <= remaining_next;
    end

    assign q_push = accept && emits;
    assign q_data = burst;

endmodule

/* rtl/core/rlp_queue.sv */
// rlp_queue: short first-word-fall-through queue of burst descriptors between
// the front and the back. Depends on rlp_pkg.
module rlp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rlp_pkg::burst_t wr_data,
    input  logic            pop,
    output rlp_pkg::burst_t rd_data,
    output logic            valid,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlp_pkg::burst_t    store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               do_push;
    logic               do_pop;

    assign valid   = (fill_reg != '0);
    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("queue fill exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");
`endif

endmodule

/* rtl/core/rlp_back.sv */
// rlp_back: serialises each queued burst into output bytes, one per cycle while
// out_stall is low, through a registered output stage. Depends on rlp_pkg.
module rlp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  rlp_pkg::burst_t head,
    input  logic            q_valid,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_error
);

    logic [rlp_pkg::CNT_W-1:0] idx_reg;
    logic [rlp_pkg::CNT_W-1:0] idx_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic                      out_error_reg;
    logic                      out_ready;
    logic                      emit;
    logic                      final_byte;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign emit       = q_valid && out_ready;
    assign final_byte = (idx_reg == head.count - 3'd1);
    assign q_pop      = emit && final_byte;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = final_byte ? '0 : idx_reg + 3'd1;
        out_valid_next = out_ready ? q_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output stage: load on emit, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= head.bytes[idx_reg];
            out_last_reg  <= head.last && final_byte;
            out_error_reg <= head.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_error_reg;

`ifndef NO_ASSERTIONS
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_error_reg) |-> (out_byte_reg == 8'h00 && !out_last_reg))
        else $error("error result carries data or last");

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg < head.count))
        else $error("byte index beyond burst length");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == '0))
        else $error("byte index not rewound while queue empty");
`endif

endmodule
